FILE: design/aabb_pkg.sv
package aabb_pkg;

  // Default coordinate width: signed Q15.8.
  localparam int unsigned CoordBitsDef = 24;

  typedef struct packed {
    logic overlap;
    logic hits_from_below;
    logic hits_from_above;
    logic hits_from_right;
    logic hits_from_left;
  } aabb_flags_t;

endpackage

FILE: design/aabb_collision_test_and_resolve.sv
// Channel   Handshake                       Payload
// input     in_valid_i / in_stall_o         self_*, other_*, velocity_i
// output    out_valid_o / out_stall_i       overlap_o, hits_from_*_o, push_x_o, push_y_o
//
// One box pair per cycle while the output is not stalled; input register, then result register.
// Edge sums, touch compares and the four-way minimum sit between the two registers.
// Reset clears only the two valid flags.
// A stalled output holds the result; the input register keeps accepting while the
// result register is free or draining, so the input stalls only when both are full.
module aabb_collision_test_and_resolve
  import aabb_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  localparam int unsigned SizeBits = COORD_BITS - 1,
  localparam int unsigned WideBits = COORD_BITS + 2,
  localparam int unsigned PushBits = COORD_BITS + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [COORD_BITS-1:0] self_left_i,
  input  logic signed [COORD_BITS-1:0] self_top_i,
  input  logic        [SizeBits-1:0]   self_width_i,
  input  logic        [SizeBits-1:0]   self_height_i,
  input  logic signed [COORD_BITS-1:0] other_left_i,
  input  logic signed [COORD_BITS-1:0] other_top_i,
  input  logic        [SizeBits-1:0]   other_width_i,
  input  logic        [SizeBits-1:0]   other_height_i,
  input  logic signed [COORD_BITS-1:0] velocity_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        overlap_o,
  output logic                        hits_from_below_o,
  output logic                        hits_from_above_o,
  output logic                        hits_from_right_o,
  output logic                        hits_from_left_o,
  output logic signed [PushBits-1:0]   push_x_o,
  output logic signed [PushBits-1:0]   push_y_o
);

  logic                         in_valid_q, in_valid_d;
  logic                         out_valid_q, out_valid_d;
  logic                         in_xfer, res_adv;

  logic signed [COORD_BITS-1:0] sl_q, st_q, ol_q, ot_q, vel_q;
  logic        [SizeBits-1:0]   sw_q, sh_q, ow_q, oh_q;

  aabb_flags_t                  flags, flags_q;
  logic signed [WideBits-1:0]   sl_w, st_w, sr_w, sb_w, ol_w, ot_w, or_w, ob_w;
  logic signed [PushBits-1:0]   push_x, push_y, push_x_q, push_y_q;

  assign res_adv    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !res_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_xfer || (in_valid_q && !res_adv);
  assign out_valid_d = res_adv ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sl_q  <= self_left_i;
      st_q  <= self_top_i;
      sw_q  <= self_width_i;
      sh_q  <= self_height_i;
      ol_q  <= other_left_i;
      ot_q  <= other_top_i;
      ow_q  <= other_width_i;
      oh_q  <= other_height_i;
      vel_q <= velocity_i;
    end
  end

  aabb_geom #(
    .CoordBits(COORD_BITS)
  ) u_geom (
    .self_left_i   (sl_q),
    .self_top_i    (st_q),
    .self_width_i  (sw_q),
    .self_height_i (sh_q),
    .other_left_i  (ol_q),
    .other_top_i   (ot_q),
    .other_width_i (ow_q),
    .other_height_i(oh_q),
    .velocity_i    (vel_q),
    .flags_o       (flags),
    .sl_o          (sl_w),
    .st_o          (st_w),
    .sr_o          (sr_w),
    .sb_o          (sb_w),
    .ol_o          (ol_w),
    .ot_o          (ot_w),
    .or_o          (or_w),
    .ob_o          (ob_w)
  );

  aabb_push #(
    .CoordBits(COORD_BITS)
  ) u_push (
    .overlap_i(flags.overlap),
    .sl_i     (sl_w),
    .st_i     (st_w),
    .sr_i     (sr_w),
    .sb_i     (sb_w),
    .ol_i     (ol_w),
    .ot_i     (ot_w),
    .or_i     (or_w),
    .ob_i     (ob_w),
    .push_x_o (push_x),
    .push_y_o (push_y)
  );

  always_ff @(posedge clk_i) begin
    if (res_adv && in_valid_q) begin
      flags_q  <= flags;
      push_x_q <= push_x;
      push_y_q <= push_y;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign overlap_o         = flags_q.overlap;
  assign hits_from_below_o = flags_q.hits_from_below;
  assign hits_from_above_o = flags_q.hits_from_above;
  assign hits_from_right_o = flags_q.hits_from_right;
  assign hits_from_left_o  = flags_q.hits_from_left;
  assign push_x_o          = push_x_q;
  assign push_y_o          = push_y_q;

endmodule

FILE: design/aabb_geom.sv
module aabb_geom
  import aabb_pkg::*;
#(
  parameter int unsigned CoordBits = CoordBitsDef,
  localparam int unsigned SizeBits = CoordBits - 1,
  localparam int unsigned WideBits = CoordBits + 2
) (
  input  logic signed [CoordBits-1:0] self_left_i,
  input  logic signed [CoordBits-1:0] self_top_i,
  input  logic        [SizeBits-1:0]  self_width_i,
  input  logic        [SizeBits-1:0]  self_height_i,
  input  logic signed [CoordBits-1:0] other_left_i,
  input  logic signed [CoordBits-1:0] other_top_i,
  input  logic        [SizeBits-1:0]  other_width_i,
  input  logic        [SizeBits-1:0]  other_height_i,
  input  logic signed [CoordBits-1:0] velocity_i,
  output aabb_flags_t                 flags_o,
  output logic signed [WideBits-1:0]  sl_o,
  output logic signed [WideBits-1:0]  st_o,
  output logic signed [WideBits-1:0]  sr_o,
  output logic signed [WideBits-1:0]  sb_o,
  output logic signed [WideBits-1:0]  ol_o,
  output logic signed [WideBits-1:0]  ot_o,
  output logic signed [WideBits-1:0]  or_o,
  output logic signed [WideBits-1:0]  ob_o
);

  // Two guard bits: bottom + |v| reaches about 3 * 2^(CoordBits-1).
  logic signed [WideBits-1:0] sl, st, sr, sb, ol, ot, orr, ob;
  logic signed [WideBits-1:0] vel_w, vmag;
  logic                       spans_x, spans_y;

  always_comb begin
    sl    = WideBits'(self_left_i);
    st    = WideBits'(self_top_i);
    ol    = WideBits'(other_left_i);
    ot    = WideBits'(other_top_i);
    sr    = sl + signed'(WideBits'(self_width_i));
    sb    = st + signed'(WideBits'(self_height_i));
    orr   = ol + signed'(WideBits'(other_width_i));
    ob    = ot + signed'(WideBits'(other_height_i));
    vel_w = WideBits'(velocity_i);
    vmag  = vel_w[WideBits-1] ? -vel_w : vel_w;

    spans_x = (sr > ol) && (sl < orr);
    spans_y = (sb > ot) && (st < ob);

    flags_o.overlap         = !((sb < ot) || (st > ob) || (sl > orr) || (sr < ol));
    flags_o.hits_from_below = ((st - vmag) < ob) && (sb > ob) && spans_x;
    flags_o.hits_from_above = ((sb + vmag) > ot) && (st < ot) && spans_x;
    flags_o.hits_from_right = ((sl - vmag) < orr) && (sr > orr) && spans_y;
    flags_o.hits_from_left  = ((sr + vmag) > ol) && (sl < ol) && spans_y;
  end

  assign sl_o = sl;
  assign st_o = st;
  assign sr_o = sr;
  assign sb_o = sb;
  assign ol_o = ol;
  assign ot_o = ot;
  assign or_o = orr;
  assign ob_o = ob;

endmodule

FILE: design/aabb_push.sv
module aabb_push
  import aabb_pkg::*;
#(
  parameter int unsigned CoordBits = CoordBitsDef,
  localparam int unsigned WideBits = CoordBits + 2,
  localparam int unsigned PushBits = CoordBits + 1
) (
  input  logic                       overlap_i,
  input  logic signed [WideBits-1:0] sl_i,
  input  logic signed [WideBits-1:0] st_i,
  input  logic signed [WideBits-1:0] sr_i,
  input  logic signed [WideBits-1:0] sb_i,
  input  logic signed [WideBits-1:0] ol_i,
  input  logic signed [WideBits-1:0] ot_i,
  input  logic signed [WideBits-1:0] or_i,
  input  logic signed [WideBits-1:0] ob_i,
  output logic signed [PushBits-1:0] push_x_o,
  output logic signed [PushBits-1:0] push_y_o
);

  logic signed [WideBits-1:0] c_top, c_bot, c_left, c_right;
  logic        [WideBits-1:0] m_top, m_bot, m_left, m_right;

  always_comb begin
    c_top   = ot_i - sb_i;
    c_bot   = ob_i - st_i;
    c_left  = ol_i - sr_i;
    c_right = or_i - sl_i;
    m_top   = c_top[WideBits-1]   ? -c_top   : c_top;
    m_bot   = c_bot[WideBits-1]   ? -c_bot   : c_bot;
    m_left  = c_left[WideBits-1]  ? -c_left  : c_left;
    m_right = c_right[WideBits-1] ? -c_right : c_right;

    push_x_o = '0;
    push_y_o = '0;
    // Smallest magnitude wins; ties resolve top, bottom, left, right.
    if (overlap_i) begin
      priority if ((m_top <= m_bot) && (m_top <= m_left) && (m_top <= m_right)) begin
        push_y_o = c_top[PushBits-1:0];
      end else if ((m_bot <= m_left) && (m_bot <= m_right)) begin
        push_y_o = c_bot[PushBits-1:0];
      end else if (m_left <= m_right) begin
        push_x_o = c_left[PushBits-1:0];
      end else begin
        push_x_o = c_right[PushBits-1:0];
      end
    end
  end

endmodule
